// ----- hw/rtl/albg_pkg.sv -----
// ----------------------------------------------------------------------------
// albg_pkg: shared types and constants of the load bar graph unit
// Field widths, display patterns and the request and status records that
// pass between the sequencer and the iterative level divider.
// ----------------------------------------------------------------------------
package albg_pkg;

   localparam int COUNT_W = 16;
   localparam int SHIFT_W = 3;
   localparam int LEVEL_W = 4;
   localparam int PORT_W  = 8;
   localparam int NUMER_W = 21;
   localparam int DENOM_W = COUNT_W + 1;
   localparam int QUOT_W  = LEVEL_W;

   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd3;
   localparam logic [COUNT_W-1:0] SCALE_RESET = 16'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 4'd10;
   localparam logic [LEVEL_W-1:0] LEVEL_KNEE  = 4'd6;
   localparam logic [LEVEL_W-1:0] LEVEL_TOP   = 4'd12;
   localparam logic [PORT_W-1:0]  RED_PORT_B  = 8'h1C;
   localparam logic [PORT_W-1:0]  RED_PORT_C  = 8'h00;
   localparam logic [PORT_W-1:0]  FULL_BAR    = 8'hFF;

   typedef struct packed {
      logic               start;
      logic [NUMER_W-1:0] numer;
      logic [DENOM_W-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } div_rsp_type;

endpackage

// ----- hw/rtl/albg_req_if.sv -----
// ----------------------------------------------------------------------------
// albg_req_if: input channel of the load bar graph unit
// Carries the pulse count of one finished measurement window.
// ----------------------------------------------------------------------------
interface albg_req_if
   import albg_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] pulse_count;

   modport source (output valid, output pulse_count, input ready);
   modport sink   (input valid, input pulse_count, output ready);
endinterface

// ----- hw/rtl/albg_rsp_if.sv -----
// ----------------------------------------------------------------------------
// albg_rsp_if: result channel of the load bar graph unit
// Carries the two port patterns, the bar level and the no activity flag.
// ----------------------------------------------------------------------------
interface albg_rsp_if
   import albg_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [PORT_W-1:0]  port_c_bits;
   logic [PORT_W-1:0]  port_b_bits;
   logic [LEVEL_W-1:0] level;
   logic               no_activity;

   modport source (output valid, output port_c_bits, output port_b_bits,
                   output level, output no_activity, input ready);
   modport sink   (input valid, input port_c_bits, input port_b_bits,
                   input level, input no_activity, output ready);
endinterface

// ----- hw/rtl/albg_csr_if.sv -----
// ----------------------------------------------------------------------------
// albg_csr_if: configuration write channel of the load bar graph unit
// Carries the write data of the count shift register.
// ----------------------------------------------------------------------------
interface albg_csr_if
   import albg_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [SHIFT_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/albg_divider.sv -----
// ----------------------------------------------------------------------------
// albg_divider: iterative restoring divider for the bar level
// One shared compare and subtract unit produces one quotient bit per cycle,
// most significant bit first, for a quotient of LEVEL_W bits.
// ----------------------------------------------------------------------------
module albg_divider
   import albg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int DSH_W = DENOM_W + QUOT_W - 1;
   localparam int CNT_W = $clog2(QUOT_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [NUMER_W-1:0]  rem_ff, rem_in;
   logic [DSH_W-1:0]    dsh_ff, dsh_in;
   logic [QUOT_W-1:0]   quot_ff, quot_in;
   logic [NUMER_W:0]    diff;
   logic                fits;

   assign diff = {1'b0, rem_ff} - (NUMER_W + 1)'(dsh_ff);
   assign fits = !diff[NUMER_W];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QUOT_W - 1);
         rem_in  = div_req.numer;
         dsh_in  = {div_req.denom, (QUOT_W - 1)'(0)};
         quot_in = '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = diff[NUMER_W-1:0];
         end
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         dsh_in  = dsh_ff >> 1;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

// ----- hw/rtl/autorange_load_bar_graph_unit.sv -----
// ----------------------------------------------------------------------------
// autorange_load_bar_graph_unit: autoranging ten step load bar graph
// Scales each window pulse count against a self growing full scale and
// drives the bar graph port patterns for the rounded idle level.
// ----------------------------------------------------------------------------
// From an accepted item to its result, a nonzero count passes the scale and
// numerator steps, the divider start and its four quotient steps, and the
// output load; a zero count goes straight to the output load.
// The input takes a new item only once the last has left the work states; it
// is not ready while an item is in work or while its result cannot enter the
// output register.
// Reset: synchronous; scale returns to 1, count shift to 3, no result held.
module autorange_load_bar_graph_unit
   import albg_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   albg_req_if.sink   req,
   albg_rsp_if.source rsp,
   albg_csr_if.sink   csr
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCALE,
      S_NUMER,
      S_WAIT,
      S_DONE
   } state_type;

   function automatic logic [COUNT_W-1:0] smear(input logic [COUNT_W-1:0] v);
      logic [COUNT_W-1:0] s;
      s = v | (v >> 1);
      s = s | (s >> 2);
      s = s | (s >> 4);
      s = s | (s >> 8);
      return s;
   endfunction

   function automatic logic [PORT_W-1:0] port_c_pattern(input logic [LEVEL_W-1:0] lv);
      logic [2*PORT_W-1:0] wide;
      wide = (2*PORT_W)'(FULL_BAR) << (LEVEL_KNEE - lv);
      return (lv > LEVEL_KNEE) ? FULL_BAR : wide[PORT_W-1:0];
   endfunction

   function automatic logic [PORT_W-1:0] port_b_pattern(input logic [LEVEL_W-1:0] lv);
      logic [2*PORT_W-1:0] wide;
      wide = (2*PORT_W)'(FULL_BAR) << (LEVEL_TOP - lv);
      return wide[PORT_W-1:0];
   endfunction

   state_type          state_ff, state_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic [COUNT_W-1:0] scale_ff, scale_in;
   logic [COUNT_W-1:0] value_ff, value_in;
   logic               red_ff, red_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               start_ff, start_in;
   logic [NUMER_W-1:0] numer_ff, numer_in;
   logic [DENOM_W-1:0] denom_ff, denom_in;
   logic               out_valid_ff, out_valid_in;
   logic [PORT_W-1:0]  out_c_ff, out_c_in;
   logic [PORT_W-1:0]  out_b_ff, out_b_in;
   logic [LEVEL_W-1:0] out_level_ff, out_level_in;
   logic               out_red_ff, out_red_in;

   logic [COUNT_W-1:0] diff;
   logic               out_free;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   assign diff     = scale_ff - value_ff;
   assign out_free = !out_valid_ff || rsp.ready;

   assign div_req.start = start_ff;
   assign div_req.numer = numer_ff;
   assign div_req.denom = denom_ff;

   albg_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      shift_in     = shift_ff;
      scale_in     = scale_ff;
      value_in     = value_ff;
      red_in       = red_ff;
      level_in     = level_ff;
      start_in     = 1'b0;
      numer_in     = numer_ff;
      denom_in     = denom_ff;
      out_valid_in = out_valid_ff;
      out_c_in     = out_c_ff;
      out_b_in     = out_b_ff;
      out_level_in = out_level_ff;
      out_red_in   = out_red_ff;

      if (csr.valid) begin
         shift_in = csr.data;
      end
      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               value_in = req.pulse_count >> shift_ff;
               red_in   = (req.pulse_count == '0);
               level_in = '0;
               state_in = (req.pulse_count == '0) ? S_DONE : S_SCALE;
            end
         end
         S_SCALE: begin
            if (value_ff > scale_ff) begin
               scale_in = smear(value_ff);
            end
            state_in = S_NUMER;
         end
         S_NUMER: begin
            numer_in = (NUMER_W'(diff) << 4) + (NUMER_W'(diff) << 2)
                       + NUMER_W'(scale_ff);
            denom_in = {scale_ff, 1'b0};
            start_in = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (div_rsp.done) begin
               level_in = (div_rsp.quot > LEVEL_MAX) ? LEVEL_MAX : div_rsp.quot;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_red_in   = red_ff;
               out_level_in = level_ff;
               out_c_in     = red_ff ? RED_PORT_C : port_c_pattern(level_ff);
               out_b_in     = red_ff ? RED_PORT_B : port_b_pattern(level_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         shift_ff     <= SHIFT_RESET;
         scale_ff     <= SCALE_RESET;
         start_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         shift_ff     <= shift_in;
         scale_ff     <= scale_in;
         start_ff     <= start_in;
         out_valid_ff <= out_valid_in;
      end
      value_ff     <= value_in;
      red_ff       <= red_in;
      level_ff     <= level_in;
      numer_ff     <= numer_in;
      denom_ff     <= denom_in;
      out_c_ff     <= out_c_in;
      out_b_ff     <= out_b_in;
      out_level_ff <= out_level_in;
      out_red_ff   <= out_red_in;
   end

   assign req.ready       = (state_ff == S_IDLE);
   assign csr.ready       = 1'b1;
   assign rsp.valid       = out_valid_ff;
   assign rsp.port_c_bits = out_c_ff;
   assign rsp.port_b_bits = out_b_ff;
   assign rsp.level       = out_level_ff;
   assign rsp.no_activity = out_red_ff;

endmodule

// ----- hw/rtl/albg_checker.sv -----
// ----------------------------------------------------------------------------
// albg_checker: port level checks of the load bar graph unit
// Watches the request and result channels of the top level and is bound to every instance.
// ----------------------------------------------------------------------------
module albg_checker
   import albg_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [PORT_W-1:0]  rsp_port_c_bits,
   input logic [PORT_W-1:0]  rsp_port_b_bits,
   input logic [LEVEL_W-1:0] rsp_level,
   input logic               rsp_no_activity
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Result item dropped while stalled.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Input ready again right after an accepted item.");

   a_red_pattern: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_activity |->
         rsp_port_c_bits == RED_PORT_C && rsp_port_b_bits == RED_PORT_B
         && rsp_level == '0)
      else $error("No activity result without the red pattern.");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_no_activity |->
         rsp_level <= LEVEL_MAX
         && (rsp_level <= LEVEL_KNEE || rsp_port_c_bits == FULL_BAR))
      else $error("Bar level out of range or lower bar not full.");

endmodule

bind autorange_load_bar_graph_unit albg_checker u_albg_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_port_c_bits (rsp.port_c_bits),
   .rsp_port_b_bits (rsp.port_b_bits),
   .rsp_level       (rsp.level),
   .rsp_no_activity (rsp.no_activity)
);

// ----- bench/albg_bar_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// albg_bar_checker: result checker of the load bar graph unit
// Watches the count, result and configuration channels, keeps its own copy
// of the full scale and the count shift, predicts the bar pattern of every
// accepted item and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module albg_bar_checker
   import albg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   albg_req_if         req,
   albg_rsp_if         rsp,
   albg_csr_if         csr,
   output int unsigned pending_bars,
   output int unsigned mismatches
);

   typedef struct packed {
      logic [PORT_W-1:0]  port_c;
      logic [PORT_W-1:0]  port_b;
      logic [LEVEL_W-1:0] level;
      logic               idle_flag;
   } bar_type;

   bar_type            bar_q[$];
   bar_type            want;
   logic [COUNT_W-1:0] full_scale;
   logic [SHIFT_W-1:0] shift_q;

   function automatic bar_type predict_bar(input logic [COUNT_W-1:0] count);
      logic [COUNT_W-1:0] value;
      logic [COUNT_W:0]   grown;
      int                 num;
      int                 den;
      int                 lvl;
      bar_type            bar;
      if (count == '0) begin
         bar.port_c    = RED_PORT_C;
         bar.port_b    = RED_PORT_B;
         bar.level     = '0;
         bar.idle_flag = 1'b1;
         return bar;
      end
      value = count >> shift_q;
      if (value > full_scale) begin
         grown = 17'd1;
         while (grown <= {1'b0, value}) begin
            grown = grown << 1;
         end
         grown = grown - 17'd1;
         full_scale = (grown > 17'h0FFFF) ? 16'hFFFF : grown[COUNT_W-1:0];
      end
      if (full_scale == '0 || value > full_scale) begin
         lvl = 0;
      end else begin
         num = 20 * (int'(full_scale) - int'(value)) + int'(full_scale);
         den = 2 * int'(full_scale);
         lvl = num / den;
         if (lvl > int'(LEVEL_MAX)) begin
            lvl = int'(LEVEL_MAX);
         end
      end
      bar.port_c    = (lvl > int'(LEVEL_KNEE)) ? FULL_BAR
                      : PORT_W'(32'hFF << (int'(LEVEL_KNEE) - lvl));
      bar.port_b    = PORT_W'(32'hFF << (int'(LEVEL_TOP) - lvl));
      bar.level     = LEVEL_W'(lvl);
      bar.idle_flag = 1'b0;
      return bar;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         bar_q.delete();
         full_scale = SCALE_RESET;
         shift_q    = SHIFT_RESET;
         mismatches = 0;
      end else begin
         if (csr.valid && csr.ready) begin
            shift_q = csr.data;
         end
         if (rsp.valid && rsp.ready) begin
            if (bar_q.size() == 0) begin
               $error("Result arrived with no item outstanding.");
               mismatches++;
            end else begin
               want = bar_q.pop_front();
               if (rsp.port_c_bits !== want.port_c) begin
                  $error("port_c_bits: expected %h, got %h", want.port_c, rsp.port_c_bits);
                  mismatches++;
               end
               if (rsp.port_b_bits !== want.port_b) begin
                  $error("port_b_bits: expected %h, got %h", want.port_b, rsp.port_b_bits);
                  mismatches++;
               end
               if (rsp.level !== want.level) begin
                  $error("level: expected %0d, got %0d", want.level, rsp.level);
                  mismatches++;
               end
               if (rsp.no_activity !== want.idle_flag) begin
                  $error("no_activity: expected %b, got %b", want.idle_flag,
                         rsp.no_activity);
                  mismatches++;
               end
            end
         end
         if (req.valid && req.ready) begin
            bar_q.push_back(predict_bar(req.pulse_count));
         end
      end
      pending_bars = bar_q.size();
   end

endmodule

// ----- bench/tb_autorange_load_bar_graph_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_autorange_load_bar_graph_unit: testbench of the load bar graph unit
// Drives directed and random pulse counts under several count shifts, with
// random gaps on the input and random stalls on the result side, and lets
// the checker compare every result with its own prediction of the bar.
// ----------------------------------------------------------------------------
module tb_autorange_load_bar_graph_unit
   import albg_pkg::*;
();

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned pending_bars;
   int unsigned mismatches;
   int          ready_hold = 0;
   int          ready_roll;
   bit          quiet = 1'b0;

   albg_req_if req_ch();
   albg_rsp_if rsp_ch();
   albg_csr_if csr_ch();

   autorange_load_bar_graph_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   albg_bar_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .csr          (csr_ch),
      .pending_bars (pending_bars),
      .mismatches   (mismatches)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold--;
      end else begin
         ready_roll = $urandom_range(0, 15);
         if (ready_roll < 3) begin
            rsp_ch.ready <= 1'b0;
            ready_hold = $urandom_range(0, 3);
         end else if (ready_roll == 3) begin
            rsp_ch.ready <= 1'b0;
            ready_hold = $urandom_range(10, 60);
         end else if (ready_roll == 4) begin
            rsp_ch.ready <= 1'b1;
            ready_hold = $urandom_range(50, 200);
         end else begin
            rsp_ch.ready <= 1'b1;
            ready_hold = $urandom_range(0, 4);
         end
      end
   end

   task automatic send_count(input logic [COUNT_W-1:0] count);
      int gap;
      int roll;
      roll = $urandom_range(0, 19);
      if (quiet || roll < 10) begin
         gap = 0;
      end else if (roll < 17) begin
         gap = $urandom_range(1, 3);
      end else if (roll < 19) begin
         gap = $urandom_range(4, 10);
      end else begin
         gap = $urandom_range(20, 50);
      end
      if (gap > 0) begin
         req_ch.valid       <= 1'b0;
         req_ch.pulse_count <= COUNT_W'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.pulse_count <= count;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_bars != 0);
   endtask

   task automatic write_shift(input logic [SHIFT_W-1:0] shift);
      wait_drained();
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= shift;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   // With ramp set, the widest count grows over the burst so that the full
   // scale climbs through its powers of two one step at a time.
   task automatic run_burst(input int n, input bit ramp);
      int               top;
      int               mag;
      int               roll;
      logic [COUNT_W:0] mask;
      for (int i = 0; i < n; i++) begin
         if (i % 64 == 0) begin
            quiet = ($urandom_range(0, 3) == 0);
         end
         top  = ramp ? 1 + (i * COUNT_W) / n : COUNT_W;
         if (top > COUNT_W) begin
            top = COUNT_W;
         end
         mag  = $urandom_range(0, top);
         mask = (17'd1 << mag) - 17'd1;
         roll = $urandom_range(0, 15);
         if (roll == 0) begin
            send_count('0);
         end else if (roll == 1) begin
            send_count(mask[COUNT_W-1:0]);
         end else begin
            send_count(mask[COUNT_W-1:0] & COUNT_W'($urandom));
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      req_ch.valid       <= 1'b0;
      req_ch.pulse_count <= '0;
      csr_ch.valid       <= 1'b0;
      csr_ch.data        <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_count(16'd0);
      send_count(16'd1);
      send_count(16'd8);
      send_count(16'd15);
      send_count(16'd16);
      send_count(16'd24);
      send_count(16'd40);

      write_shift(3'd7);
      run_burst(500, 1'b1);

      write_shift(3'd0);
      run_burst(500, 1'b1);
      send_count(16'hFFFF);
      send_count(16'hFFFE);
      send_count(16'h8000);
      send_count(16'h7FFF);
      send_count(16'h5555);
      send_count(16'hAAAA);
      send_count(16'h0001);
      send_count(16'h0000);
      send_count(16'h0CCC);

      write_shift(3'd4);
      run_burst(400, 1'b0);
      send_count(16'h000F);

      write_shift(3'd2);
      run_burst(400, 1'b0);
      send_count(16'h0003);

      wait_drained();
      repeat (30) @(posedge clock);
      if (mismatches == 0 && pending_bars == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/albg_pkg.sv
hw/rtl/albg_req_if.sv
hw/rtl/albg_rsp_if.sv
hw/rtl/albg_csr_if.sv
hw/rtl/albg_divider.sv
hw/rtl/autorange_load_bar_graph_unit.sv
hw/rtl/albg_checker.sv
bench/albg_bar_checker.sv
bench/tb_autorange_load_bar_graph_unit.sv
